>>> design/ttc_pkg.sv
// Shared widths, constants and types of the timestamp to calendar converter.
`timescale 1ns / 1ps

package ttc_pkg;

	// Field widths of the two channels.
	localparam int STAMP_W  = 64;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int FRAC_W   = 10;

	// Time of day is peeled off as six mixed-radix digits, least significant first.
	localparam int DIGIT_W   = 10;
	localparam int DIV_NUM   = 6;
	localparam int DIG_NS    = 0;
	localparam int DIG_US    = 1;
	localparam int DIG_MS    = 2;
	localparam int DIG_SEC   = 3;
	localparam int DIG_MIN   = 4;
	localparam int DIG_HOUR  = 5;

	// Each division walks the dividend in chunks, one reciprocal multiply per chunk.
	localparam int CHUNK_W     = 16;
	localparam int CHUNK_NUM   = STAMP_W / CHUNK_W;
	localparam int STEP_NUM    = DIV_NUM * CHUNK_NUM;
	localparam int DIV_X_W     = DIGIT_W + CHUNK_W;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 36;
	localparam int DIV_PROD_W  = DIV_X_W + RECIP_W;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [DIV_NUM-1:0] digits_t;

	localparam digit_t DIV_CONST [DIV_NUM] = '{
		10'd1000, 10'd1000, 10'd1000, 10'd60, 10'd60, 10'd24
	};

	// Rounded-up reciprocals scaled by two to the RECIP_SHIFT; exact for every chunk step.
	localparam logic [RECIP_W-1:0] DIV_RECIP [DIV_NUM] = '{
		32'd68719477, 32'd68719477, 32'd68719477,
		32'd1145324613, 32'd1145324613, 32'd2863311531
	};

	// Two to the 63rd nanoseconds as 106751 days 23:47:16.854775808.
	localparam digit_t HALF_OFFSET [DIV_NUM] = '{
		10'd808, 10'd775, 10'd854, 10'd16, 10'd47, 10'd23
	};

	// Days from 0001-01-01 to the epoch, less the days of the sign offset.
	localparam int DAYS_W      = 20;
	localparam int OFFSET_DAYS = 719162 - 106751;

	localparam int DAYS_400Y = 146097;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_4Y   = 1461;
	localparam int DAYS_1Y   = 365;
	localparam int YEARS_400 = 400;
	localparam int YEARS_100 = 100;
	localparam int YEARS_4   = 4;

	localparam int ERA_MAX  = ((1 << DAYS_W) - 1) / DAYS_400Y;
	localparam int ERA_W    = $clog2(ERA_MAX + 1);
	localparam int PD_W     = $clog2(DAYS_400Y);
	localparam int CENT_W   = 2;
	localparam int CENT_MAX = 4;
	localparam int CD_W     = $clog2(DAYS_100Y + 1);
	localparam int Q4_W     = $clog2(DAYS_100Y / DAYS_4Y + 1);
	localparam int Q4_LAST  = DAYS_100Y / DAYS_4Y;
	localparam int QD_W     = $clog2(DAYS_4Y);
	localparam int YR_W     = 2;
	localparam int YR_MAX   = 4;
	localparam int YR_LAST  = 3;
	localparam int CENT_LAST = 3;
	localparam int YD_W     = $clog2(DAYS_1Y + 1);

	// cd / 1461 as (cd * Q4_RECIP) >> Q4_SHIFT, exact for cd below 2^16.
	localparam int Q4_RECIP  = 91868;
	localparam int Q4_SHIFT  = 27;
	localparam int Q4_PROD_W = CD_W + 17;

	localparam int MONTH_NUM = 12;
	localparam int LEAP_MONTH_FIRST = 2;
	localparam logic [YD_W-1:0] MONTH_START [MONTH_NUM] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// One chunk step of the time-of-day divisions.
	typedef struct packed {
		logic [STAMP_W-1:0] val;
		digit_t             rem;
		digits_t            dig;
	} dv_state_t;

endpackage

>>> design/ttc_stamp_if.sv
// Input channel carrying one signed nanosecond timestamp per request.
`timescale 1ns / 1ps

interface ttc_stamp_if import ttc_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [STAMP_W-1:0]  timestamp_ns;

	modport source (output valid, output timestamp_ns, input ready);
	modport sink   (input valid, input timestamp_ns, output ready);
endinterface

>>> design/ttc_cal_if.sv
// Output channel carrying one calendar date and time of day per request.
`timescale 1ns / 1ps

interface ttc_cal_if import ttc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [MDAY_W-1:0]   day_of_month;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;
	logic [FRAC_W-1:0]   millisecond;
	logic [FRAC_W-1:0]   microsecond;
	logic [FRAC_W-1:0]   nanosecond;

	modport source (
		output valid, output year, output month, output day_of_month, output hour,
		output minute, output second, output millisecond, output microsecond,
		output nanosecond, input ready
	);
	modport sink (
		input valid, input year, input month, input day_of_month, input hour,
		input minute, input second, input millisecond, input microsecond,
		input nanosecond, output ready
	);
endinterface

>>> design/timestamp_to_calendar_core.sv
// Throughput one request per cycle while the output is not stalled.
// The pipeline is six chained divisions by constants (1000, 1000, 1000, 60, 60, 24),
// each walking four 16-bit chunks in two stages per chunk, then seven calendar stages.
// A stalled output freezes the whole pipeline in place, bubbles included, and holds off input.
// Reset clears only the valid bits; data registers load whenever the pipeline advances.
`timescale 1ns / 1ps

module timestamp_to_calendar_core import ttc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ttc_stamp_if.sink stamp,
	ttc_cal_if.source cal
);

	logic adv;

	// Division chunk steps: stage a multiplies, stage b forms quotient chunk and remainder.
	logic                  vld_a_s [STEP_NUM];
	logic                  vld_b_s [STEP_NUM];
	dv_state_t             dva_s   [STEP_NUM];
	logic [DIV_X_W-1:0]    dvx_s   [STEP_NUM];
	logic [DIV_PROD_W-1:0] dvp_s   [STEP_NUM];
	dv_state_t             dvb_s   [STEP_NUM];

	// Calendar stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	digits_t tod_s1, tod_s2, tod_s3, tod_s4, tod_s5, tod_s6, tod_s7;
	logic [DAYS_W-1:0]  d_s1;
	logic [ERA_W-1:0]   p_s2, p_s3, p_s4, p_s5;
	logic [PD_W-1:0]    pd_s2;
	logic [CENT_W-1:0]  c_s3, c_s4, c_s5;
	logic [CD_W-1:0]    cd_s3, cd_s4;
	logic [Q4_W-1:0]    q4_s4, q4_s5;
	logic [QD_W-1:0]    qd_s5;
	logic [YEAR_W-1:0]  year_s6, year_s7;
	logic [YD_W-1:0]    yd_s6;
	logic               leap_s6;
	logic [MONTH_W-1:0] month_s7;
	logic [MDAY_W-1:0]  mday_s7;

	assign adv         = !vld_s7 || cal.ready;
	assign stamp.ready = adv;

	for (genvar j = 0; j < STEP_NUM; j++) begin : g_step
		localparam int I  = j / CHUNK_NUM;
		localparam int K  = j % CHUNK_NUM;
		localparam int LO = STAMP_W - CHUNK_W * (K + 1);

		dv_state_t          src;
		logic               src_vld;
		logic [DIV_X_W-1:0] x;
		logic [CHUNK_W-1:0] quo;
		logic [DIV_X_W-1:0] rem_wide;
		dv_state_t          nxt;

		if (j == 0) begin : g_first
			// Flipping the sign bit adds 2^63, so the divisions see an unsigned value.
			always_comb begin
				src     = '0;
				src.val = {~stamp.timestamp_ns[STAMP_W-1], stamp.timestamp_ns[STAMP_W-2:0]};
				src_vld = stamp.valid;
			end
		end else begin : g_chain
			assign src     = dvb_s[j-1];
			assign src_vld = vld_b_s[j-1];
		end

		assign x = {src.rem, src.val[LO +: CHUNK_W]};

		always_comb begin
			quo      = dvp_s[j][RECIP_SHIFT +: CHUNK_W];
			rem_wide = dvx_s[j] - DIV_X_W'(quo) * DIV_X_W'(DIV_CONST[I]);
			nxt      = dva_s[j];
			nxt.val[LO +: CHUNK_W] = quo;
			if (K == CHUNK_NUM - 1) begin
				nxt.dig[I] = rem_wide[DIGIT_W-1:0];
				nxt.rem    = '0;
			end else begin
				nxt.rem = rem_wide[DIGIT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s[j] <= 1'b0;
				vld_b_s[j] <= 1'b0;
			end else if (adv) begin
				vld_a_s[j] <= src_vld;
				vld_b_s[j] <= vld_a_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dva_s[j] <= src;
				dvx_s[j] <= x;
				dvp_s[j] <= DIV_PROD_W'(x) * DIV_PROD_W'(DIV_RECIP[I]);
				dvb_s[j] <= nxt;
			end
		end
	end

	// Stage 1: remove the 2^63 offset digit by digit with borrow, giving floored results.
	dv_state_t         dv_last;
	logic [DIGIT_W:0]  diff;
	logic              borrow;
	digits_t           tod_nx;
	logic [DAYS_W-1:0] d_nx;

	assign dv_last = dvb_s[STEP_NUM-1];

	always_comb begin
		borrow = 1'b0;
		diff   = '0;
		tod_nx = '0;
		for (int i = 0; i < DIV_NUM; i++) begin
			diff = {1'b0, dv_last.dig[i]} - {1'b0, HALF_OFFSET[i]} - (DIGIT_W + 1)'(borrow);
			if (diff[DIGIT_W]) begin
				tod_nx[i] = DIGIT_W'(diff + (DIGIT_W + 1)'(DIV_CONST[i]));
			end else begin
				tod_nx[i] = diff[DIGIT_W-1:0];
			end
			borrow = diff[DIGIT_W];
		end
		d_nx = DAYS_W'(dv_last.val) + DAYS_W'(OFFSET_DAYS) - DAYS_W'(borrow);
	end

	// Stage 2: 400-year cycles.
	logic [ERA_W-1:0]  p_nx;
	logic [DAYS_W-1:0] base400;
	logic [PD_W-1:0]   pd_nx;

	always_comb begin
		p_nx    = '0;
		base400 = '0;
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (d_s1 >= DAYS_W'(k * DAYS_400Y)) begin
				p_nx    = ERA_W'(k);
				base400 = DAYS_W'(k * DAYS_400Y);
			end
		end
		pd_nx = PD_W'(d_s1 - base400);
	end

	// Stage 3: centuries, with the last century of a cycle taking the extra day.
	logic [CENT_W-1:0] c_nx;
	logic [PD_W-1:0]   base100;
	logic [CD_W-1:0]   cd_nx;

	always_comb begin
		c_nx    = '0;
		base100 = '0;
		for (int k = 1; k < CENT_MAX; k++) begin
			if (pd_s2 >= PD_W'(k * DAYS_100Y)) begin
				c_nx    = CENT_W'(k);
				base100 = PD_W'(k * DAYS_100Y);
			end
		end
		if (pd_s2 >= PD_W'(CENT_MAX * DAYS_100Y)) begin
			cd_nx = CD_W'(DAYS_100Y);
		end else begin
			cd_nx = CD_W'(pd_s2 - base100);
		end
	end

	// Stage 4: four-year cycles by reciprocal multiply.
	logic [Q4_PROD_W-1:0] q4_prod;
	logic [Q4_W-1:0]      q4_nx;

	always_comb begin
		q4_prod = Q4_PROD_W'(cd_s3) * Q4_PROD_W'(Q4_RECIP);
		q4_nx   = Q4_W'(q4_prod >> Q4_SHIFT);
	end

	// Stage 5: day within the four-year cycle.
	logic [QD_W-1:0] qd_nx;

	assign qd_nx = QD_W'(cd_s4 - CD_W'(q4_s4) * CD_W'(DAYS_4Y));

	// Stage 6: single years, with the leap year of the cycle taking the extra day.
	logic [YR_W-1:0]   y_nx;
	logic [QD_W-1:0]   base1;
	logic [YD_W-1:0]   yd_nx;
	logic [YEAR_W-1:0] year_nx;
	logic              leap_nx;

	always_comb begin
		y_nx  = '0;
		base1 = '0;
		for (int k = 1; k < YR_MAX; k++) begin
			if (qd_s5 >= QD_W'(k * DAYS_1Y)) begin
				y_nx  = YR_W'(k);
				base1 = QD_W'(k * DAYS_1Y);
			end
		end
		if (qd_s5 >= QD_W'(YR_MAX * DAYS_1Y)) begin
			yd_nx = YD_W'(DAYS_1Y);
		end else begin
			yd_nx = YD_W'(qd_s5 - base1);
		end
		year_nx = YEAR_W'(p_s5) * YEAR_W'(YEARS_400) + YEAR_W'(c_s5) * YEAR_W'(YEARS_100)
			+ YEAR_W'(q4_s5) * YEAR_W'(YEARS_4) + YEAR_W'(y_nx) + YEAR_W'(1);
		// Divisible by four, and a century year only when it closes a 400-year cycle.
		leap_nx = (y_nx == YR_W'(YR_LAST))
			&& ((q4_s5 != Q4_W'(Q4_LAST)) || (c_s5 == CENT_W'(CENT_LAST)));
	end

	// Stage 7: month and day of month.
	logic [MONTH_W-1:0] month_nx;
	logic [MDAY_W-1:0]  mday_nx;
	logic [YD_W-1:0]    mstart;
	logic [YD_W-1:0]    mbase;

	always_comb begin
		month_nx = '0;
		mbase    = '0;
		mstart   = '0;
		for (int k = 1; k < MONTH_NUM; k++) begin
			mstart = MONTH_START[k] + YD_W'(leap_s6 && (k >= LEAP_MONTH_FIRST));
			if (yd_s6 >= mstart) begin
				month_nx = MONTH_W'(k);
				mbase    = mstart;
			end
		end
		month_nx = month_nx + MONTH_W'(1);
		mday_nx  = MDAY_W'(yd_s6 - mbase + YD_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_b_s[STEP_NUM-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tod_s1   <= tod_nx;
			d_s1     <= d_nx;

			tod_s2   <= tod_s1;
			p_s2     <= p_nx;
			pd_s2    <= pd_nx;

			tod_s3   <= tod_s2;
			p_s3     <= p_s2;
			c_s3     <= c_nx;
			cd_s3    <= cd_nx;

			tod_s4   <= tod_s3;
			p_s4     <= p_s3;
			c_s4     <= c_s3;
			cd_s4    <= cd_s3;
			q4_s4    <= q4_nx;

			tod_s5   <= tod_s4;
			p_s5     <= p_s4;
			c_s5     <= c_s4;
			q4_s5    <= q4_s4;
			qd_s5    <= qd_nx;

			tod_s6   <= tod_s5;
			year_s6  <= year_nx;
			yd_s6    <= yd_nx;
			leap_s6  <= leap_nx;

			tod_s7   <= tod_s6;
			year_s7  <= year_s6;
			month_s7 <= month_nx;
			mday_s7  <= mday_nx;
		end
	end

	assign cal.valid        = vld_s7;
	assign cal.year         = year_s7;
	assign cal.month        = month_s7;
	assign cal.day_of_month = mday_s7;
	assign cal.hour         = HOUR_W'(tod_s7[DIG_HOUR]);
	assign cal.minute       = MINUTE_W'(tod_s7[DIG_MIN]);
	assign cal.second       = SECOND_W'(tod_s7[DIG_SEC]);
	assign cal.millisecond  = FRAC_W'(tod_s7[DIG_MS]);
	assign cal.microsecond  = FRAC_W'(tod_s7[DIG_US]);
	assign cal.nanosecond   = FRAC_W'(tod_s7[DIG_NS]);

endmodule

>>> verif/tb.sv
// Self-checking testbench of the timestamp to calendar converter with a built-in predictor.
`timescale 1ns / 1ps

module tb import ttc_pkg::*;;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [MDAY_W-1:0]   day_of_month;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [FRAC_W-1:0]   millisecond;
		logic [FRAC_W-1:0]   microsecond;
		logic [FRAC_W-1:0]   nanosecond;
	} cal_t;

	typedef struct packed {
		logic signed [STAMP_W-1:0] stamp;
		logic                      typed;
		cal_t                      want;
	} stim_row_t;

	localparam int FIELD_NUM = 9;
	typedef int unsigned field_vals_t [FIELD_NUM];

	localparam string FIELD_NAME [FIELD_NUM] = '{
		"year", "month", "day_of_month", "hour", "minute", "second",
		"millisecond", "microsecond", "nanosecond"
	};

	localparam longint NS_DAY = 64'sd86400000000000;
	localparam longint unsigned NS_HOUR = 64'd3600000000000;
	localparam longint unsigned NS_MINUTE = 64'd60000000000;
	localparam longint unsigned NS_SECOND = 64'd1000000000;
	localparam longint unsigned NS_MILLI = 64'd1000000;
	localparam longint unsigned NS_MICRO = 64'd1000;
	localparam longint DAYS_TO_EPOCH = 64'sd719162;
	localparam int DAY_LO = -106751;
	localparam int DAY_HI = 106750;
	localparam longint STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint STAMP_MIN = 64'sh8000_0000_0000_0000;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int RANDOM_ITEMS = 1080;
	localparam int QUIET_ITEMS = 150;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 70;

	localparam cal_t CAL_NONE = '0;
	localparam int DIRECTED_NUM = 24;

	// Rows with a typed expectation are the epoch, the extremes and the day edges around them.
	localparam stim_row_t DIRECTED [DIRECTED_NUM] = '{
		'{64'sd0, 1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 10'd0, 10'd0}},
		'{64'sd1, 1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 10'd0, 10'd1}},
		'{-64'sd1, 1'b1,
			'{12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999, 10'd999, 10'd999}},
		'{STAMP_MAX, 1'b1,
			'{12'd2262, 4'd4, 5'd11, 5'd23, 6'd47, 6'd16, 10'd854, 10'd775, 10'd807}},
		'{STAMP_MIN, 1'b1,
			'{12'd1677, 4'd9, 5'd21, 5'd0, 6'd12, 6'd43, 10'd145, 10'd224, 10'd192}},
		'{NS_DAY - 64'sd1, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 10'd999, 10'd999, 10'd999}},
		'{-NS_DAY, 1'b1,
			'{12'd1969, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0, 10'd0, 10'd0}},
		'{-NS_DAY - 64'sd1, 1'b1,
			'{12'd1969, 4'd12, 5'd30, 5'd23, 6'd59, 6'd59, 10'd999, 10'd999, 10'd999}},
		'{64'sd11016 * NS_DAY, 1'b0, CAL_NONE},
		'{64'sd11017 * NS_DAY - 64'sd1, 1'b0, CAL_NONE},
		'{64'sd11017 * NS_DAY, 1'b0, CAL_NONE},
		'{-64'sd25508 * NS_DAY - 64'sd1, 1'b0, CAL_NONE},
		'{-64'sd25508 * NS_DAY, 1'b0, CAL_NONE},
		'{64'sd47541 * NS_DAY - 64'sd1, 1'b0, CAL_NONE},
		'{64'sd47541 * NS_DAY, 1'b0, CAL_NONE},
		'{64'sd789 * NS_DAY, 1'b0, CAL_NONE},
		'{64'sd790 * NS_DAY - 64'sd1, 1'b0, CAL_NONE},
		'{64'sd1094 * NS_DAY, 1'b0, CAL_NONE},
		'{64'sd1095 * NS_DAY - 64'sd1, 1'b0, CAL_NONE},
		'{64'sh5555_5555_5555_5555, 1'b0, CAL_NONE},
		'{64'shAAAA_AAAA_AAAA_AAAA, 1'b0, CAL_NONE},
		'{STAMP_MIN + 64'sd1, 1'b0, CAL_NONE},
		'{STAMP_MAX - 64'sd1, 1'b0, CAL_NONE},
		'{-64'sd106752 * NS_DAY + NS_DAY, 1'b0, CAL_NONE}
	};

	logic clk;
	logic arst_n;

	ttc_stamp_if stamp_ch ();
	ttc_cal_if   cal_ch ();

	timestamp_to_calendar_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp_ch),
		.cal    (cal_ch)
	);

	cal_t pending_dates [$];
	int   error_cnt = 0;
	int   quiet_cycles = 0;
	bit   tx_idle_en;
	bit   rx_idle_en;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floored day split of the timestamp, then the Gregorian cycle breakdown of the day number.
	function automatic cal_t calendar_of(input longint ts);
		longint day_num;
		longint day_ns;
		longint unsigned tod;
		int unsigned days;
		int unsigned era;
		int unsigned era_day;
		int unsigned cent;
		int unsigned cent_day;
		int unsigned quad;
		int unsigned q4_day;
		int unsigned yr_in_quad;
		int unsigned yday;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		bit leap;
		cal_t c;
		day_num = ts / NS_DAY;
		day_ns = ts % NS_DAY;
		if (day_ns < 0) begin
			day_num = day_num - 1;
			day_ns = day_ns + NS_DAY;
		end
		tod = longint'(day_ns);
		days = 32'(day_num + DAYS_TO_EPOCH);
		era = days / DAYS_400Y;
		era_day = days % DAYS_400Y;
		cent = era_day / DAYS_100Y;
		cent_day = era_day % DAYS_100Y;
		if (cent == 4) begin
			cent = 3;
			cent_day = DAYS_100Y;
		end
		quad = cent_day / DAYS_4Y;
		q4_day = cent_day % DAYS_4Y;
		yr_in_quad = q4_day / DAYS_1Y;
		yday = q4_day % DAYS_1Y;
		if (yr_in_quad == 4) begin
			yr_in_quad = 3;
			yday = DAYS_1Y;
		end
		yr = era * 400 + cent * 100 + quad * 4 + yr_in_quad + 1;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		mon = 0;
		while (mon < 11) begin
			mlen = MONTH_DAYS[mon];
			if (mon == 1 && leap)
				mlen = 29;
			if (yday < mlen)
				break;
			yday = yday - mlen;
			mon++;
		end
		c.year = YEAR_W'(yr);
		c.month = MONTH_W'(mon + 1);
		c.day_of_month = MDAY_W'(yday + 1);
		c.hour = HOUR_W'(tod / NS_HOUR);
		c.minute = MINUTE_W'((tod / NS_MINUTE) % 60);
		c.second = SECOND_W'((tod / NS_SECOND) % 60);
		c.millisecond = FRAC_W'((tod / NS_MILLI) % 1000);
		c.microsecond = FRAC_W'((tod / NS_MICRO) % 1000);
		c.nanosecond = FRAC_W'(tod % 1000);
		return c;
	endfunction

	function automatic field_vals_t fields_of(input cal_t c);
		field_vals_t v;
		v = '{c.year, c.month, c.day_of_month, c.hour, c.minute, c.second,
			c.millisecond, c.microsecond, c.nanosecond};
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_stamp(input longint ts, input cal_t want);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			stamp_ch.valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		stamp_ch.valid = 1'b1;
		stamp_ch.timestamp_ns = ts;
		do
			@(posedge clk);
		while (!stamp_ch.ready);
		pending_dates.push_back(want);
		@(negedge clk);
	endtask

	function automatic longint random_stamp();
		longint ts;
		longint day_num;
		longint unsigned wide;
		day_num = longint'(int'($urandom_range(0, DAY_HI - DAY_LO)) + DAY_LO);
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ts = longint'(wide);
			4, 5, 6: ts = day_num * NS_DAY + longint'(int'($urandom_range(0, 2000)) - 1000);
			7: ts = STAMP_MAX - longint'($urandom_range(0, 1 << 20));
			8: ts = STAMP_MIN + longint'($urandom_range(0, 1 << 20));
			default: ts = day_num * NS_DAY + longint'(wide % longint'(NS_DAY));
		endcase
		return ts;
	endfunction

	// Output side: ready drops for short bursts while stalling is enabled.
	initial begin
		cal_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				cal_ch.ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				cal_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cal_t got;
		cal_t want;
		field_vals_t gv;
		field_vals_t wv;
		if (arst_n && cal_ch.valid && cal_ch.ready) begin
			got = '{cal_ch.year, cal_ch.month, cal_ch.day_of_month, cal_ch.hour,
				cal_ch.minute, cal_ch.second, cal_ch.millisecond, cal_ch.microsecond,
				cal_ch.nanosecond};
			if (pending_dates.size() == 0) begin
				$display("[%0t] unexpected result: expected none, got %p", $time, got);
				error_cnt++;
			end else begin
				want = pending_dates.pop_front();
				gv = fields_of(got);
				wv = fields_of(want);
				for (int i = 0; i < FIELD_NUM; i++) begin
					if (gv[i] !== wv[i]) begin
						$display("[%0t] mismatch on %s: expected %0d, got %0d",
							$time, FIELD_NAME[i], wv[i], gv[i]);
						error_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((stamp_ch.valid && stamp_ch.ready) || (cal_ch.valid && cal_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		longint ts;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		arst_n = 1'b0;
		stamp_ch.valid = 1'b0;
		stamp_ch.timestamp_ns = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_stamp(DIRECTED[i].stamp,
				DIRECTED[i].typed ? DIRECTED[i].want : calendar_of(DIRECTED[i].stamp));

		// Hold the input off until the pipeline has drained completely.
		stamp_ch.valid = 1'b0;
		while (pending_dates.size() != 0)
			@(negedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end else if (n % 100 == 0) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
			end
			ts = random_stamp();
			send_stamp(ts, calendar_of(ts));
		end
		stamp_ch.valid = 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
design/ttc_pkg.sv
design/ttc_stamp_if.sv
design/ttc_cal_if.sv
design/timestamp_to_calendar_core.sv
verif/tb.sv
